// File: hw/rtl/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg: shared definitions for the sigmoid forward/backward core
// constants, opcode type, stage payload structs and the sigmoid table
// ----------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

  // table resolution and fixed-point format
  localparam int TABLE_BITS = 8;
  localparam int FRAC_BITS  = 12;

  localparam int DATA_W   = 16;
  localparam int MAG_W    = DATA_W - 1;
  localparam int ROM_SIZE = (1 << TABLE_BITS) + 1;
  localparam int ROM_IW   = TABLE_BITS + 1;
  localparam int POS_BITS = 19 - TABLE_BITS;
  localparam int U_W      = 19;
  localparam int SHIFT    = 16 - FRAC_BITS;
  localparam int S_W      = 17;
  localparam int D_W      = 31;
  localparam int P_W      = 47;

  // |z| saturates just below 8.0
  localparam int LIMIT_RAW = (8 << FRAC_BITS) - 1;
  localparam int MAG_LIMIT = (LIMIT_RAW > 32767) ? 32767 : LIMIT_RAW;

  // 1.0 in q0.16
  localparam logic [S_W-1:0] ONE = S_W'(1 << 16);

  typedef enum logic {
    OP_FWD = 1'b0,
    OP_BWD = 1'b1
  } op_t;

  // after magnitude / saturation
  typedef struct packed {
    op_t                     op;
    logic                    neg;
    logic [TABLE_BITS-1:0]   idx;
    logic [POS_BITS-1:0]     fr;
    logic signed [DATA_W-1:0] grad;
  } front_t;

  // after table read
  typedef struct packed {
    op_t                     op;
    logic                    neg;
    logic [POS_BITS-1:0]     fr;
    logic [15:0]             lo;
    logic [15:0]             diff;
    logic signed [DATA_W-1:0] grad;
  } lut_t;

  // signed-corrected sigmoid, q0.16
  typedef struct packed {
    op_t                     op;
    logic [S_W-1:0]          s;
    logic signed [DATA_W-1:0] grad;
  } sig_t;

  // forward answer and s*(1-s) in q0.32
  typedef struct packed {
    op_t                     op;
    logic signed [DATA_W-1:0] fwd;
    logic [D_W-1:0]          d;
    logic signed [DATA_W-1:0] grad;
  } deriv_t;

  // forward answer and full backward product
  typedef struct packed {
    op_t                     op;
    logic signed [DATA_W-1:0] fwd;
    logic signed [P_W-1:0]   p;
  } prod_t;

  typedef logic [15:0] rom_t [ROM_SIZE];

  // shift and subtract quotient, used only while building the table
  function automatic longint unsigned quot64(longint unsigned num,
                                             longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      q = q << 1;
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^x in q32 by a truncated series, x = 8k/2^TABLE_BITS, then
  // round(65536*E/(E+2^32)) with ties going up
  function automatic logic [15:0] rom_entry(int unsigned k);
    longint unsigned term;
    longint unsigned e;
    longint unsigned den;
    term = 64'd1 << 32;
    e    = term;
    for (int n = 1; n < 200 && term != 0; n++) begin
      term = quot64(term * 64'(k) * 64'd8, 64'(n) << TABLE_BITS);
      e    = e + term;
    end
    den = e + (64'd1 << 32);
    return 16'(quot64(e * 64'd131072 + den, den << 1));
  endfunction

  // entry k = round(65536 / (1 + e^-(8k/2^TABLE_BITS))), evaluated at elaboration
  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < ROM_SIZE; k++) begin
      r[k] = rom_entry(k);
    end
    return r;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

endpackage

`default_nettype wire

// File: hw/rtl/sfb_lookup.sv
// ----------------------------------------------------------------------------
// sfb_lookup: magnitude, saturation and sigmoid table read
// two register stages: table address, then the two neighboring entries
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_lookup (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire sfb_pkg::op_t                    in_op,
  input  wire logic signed [sfb_pkg::DATA_W-1:0] in_z,
  input  wire logic signed [sfb_pkg::DATA_W-1:0] in_grad,
  output logic                                 out_valid,
  output sfb_pkg::lut_t                        out_data
);

  logic                          neg;
  logic [sfb_pkg::DATA_W-1:0]    mag_full;
  logic [sfb_pkg::MAG_W-1:0]     mag;
  logic [sfb_pkg::U_W-1:0]       u;
  sfb_pkg::front_t               front_next;

  logic                          v1;
  sfb_pkg::front_t               front;

  logic [sfb_pkg::ROM_IW-1:0]    lo_addr;
  logic [sfb_pkg::ROM_IW-1:0]    hi_addr;
  logic [15:0]                   lo_val;
  logic [15:0]                   hi_val;
  sfb_pkg::lut_t                 lut_next;

  // stage 1: |z| (most negative value wraps to 32768 unsigned), clamp, split
  always_comb begin
    neg      = in_z[sfb_pkg::DATA_W-1];
    mag_full = neg ? sfb_pkg::DATA_W'(-in_z) : sfb_pkg::DATA_W'(in_z);
    if (mag_full > sfb_pkg::DATA_W'(sfb_pkg::MAG_LIMIT)) begin
      mag = sfb_pkg::MAG_W'(sfb_pkg::MAG_LIMIT);
    end else begin
      mag = mag_full[sfb_pkg::MAG_W-1:0];
    end
    u                = sfb_pkg::U_W'(mag) << sfb_pkg::SHIFT;
    front_next.op    = in_op;
    front_next.neg   = neg;
    front_next.idx   = u[sfb_pkg::U_W-1 -: sfb_pkg::TABLE_BITS];
    front_next.fr    = u[sfb_pkg::POS_BITS-1:0];
    front_next.grad  = in_grad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= front_next;
    end
  end

  // stage 2: neighboring table entries
  always_comb begin
    lo_addr        = {1'b0, front.idx};
    hi_addr        = lo_addr + sfb_pkg::ROM_IW'(1);
    lo_val         = sfb_pkg::SIG_ROM[lo_addr];
    hi_val         = sfb_pkg::SIG_ROM[hi_addr];
    lut_next.op    = front.op;
    lut_next.neg   = front.neg;
    lut_next.fr    = front.fr;
    lut_next.lo    = lo_val;
    // table is monotonic, the difference never goes negative
    lut_next.diff  = hi_val - lo_val;
    lut_next.grad  = front.grad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= lut_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sfb_interp.sv
// ----------------------------------------------------------------------------
// sfb_interp: linear interpolation between table entries
// one register stage, applies 1-s for negative inputs
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_interp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire sfb_pkg::lut_t in_data,
  output logic               out_valid,
  output sfb_pkg::sig_t      out_data
);

  localparam int IP_W = 16 + sfb_pkg::POS_BITS + 1;

  logic [IP_W-1:0]          ip;
  logic [15:0]              step;
  logic [sfb_pkg::S_W-1:0]  s_pos;
  sfb_pkg::sig_t            sig_next;

  always_comb begin
    // rounded half up
    ip    = IP_W'(in_data.diff) * IP_W'(in_data.fr)
          + IP_W'(1 << (sfb_pkg::POS_BITS - 1));
    step  = 16'(ip >> sfb_pkg::POS_BITS);
    s_pos = sfb_pkg::S_W'(in_data.lo) + sfb_pkg::S_W'(step);
    sig_next.op   = in_data.op;
    sig_next.s    = in_data.neg ? (sfb_pkg::ONE - s_pos) : s_pos;
    sig_next.grad = in_data.grad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= sig_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sfb_deriv.sv
// ----------------------------------------------------------------------------
// sfb_deriv: forward rounding and derivative-times-gradient path
// three register stages: s*(1-s), product with grad, round and select
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_deriv (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire sfb_pkg::sig_t                     in_data,
  output logic                                   out_valid,
  output logic signed [sfb_pkg::DATA_W-1:0]      out_value
);

  localparam int FS_W = sfb_pkg::S_W;
  localparam logic [FS_W-1:0] FWD_HALF = FS_W'(1 << (sfb_pkg::SHIFT - 1));
  localparam logic signed [sfb_pkg::P_W:0] BWD_HALF =
    (sfb_pkg::P_W + 1)'(1) <<< 31;

  logic [FS_W-1:0]                    fsum;
  logic [2*sfb_pkg::S_W-1:0]          d_full;
  sfb_pkg::deriv_t                    deriv_next;

  logic                               v4;
  sfb_pkg::deriv_t                    deriv;

  logic signed [sfb_pkg::P_W:0]       d_ext;
  logic signed [sfb_pkg::P_W:0]       g_ext;
  logic signed [sfb_pkg::P_W:0]       p_full;
  sfb_pkg::prod_t                     prod_next;

  logic                               v5;
  sfb_pkg::prod_t                     prod;

  logic signed [sfb_pkg::P_W:0]       rsum;
  logic signed [sfb_pkg::DATA_W-1:0]  value_next;

  // stage 4: forward rounding (at most 1.0, no clamp reachable) and s*(1-s)
  always_comb begin
    fsum              = in_data.s + FWD_HALF;
    d_full            = (2*sfb_pkg::S_W)'(in_data.s)
                      * (2*sfb_pkg::S_W)'(sfb_pkg::ONE - in_data.s);
    deriv_next.op     = in_data.op;
    deriv_next.fwd    = sfb_pkg::DATA_W'(fsum >> sfb_pkg::SHIFT);
    // peak is 2^30 at s = 0.5
    deriv_next.d      = d_full[sfb_pkg::D_W-1:0];
    deriv_next.grad   = in_data.grad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deriv <= deriv_next;
    end
  end

  // stage 5: exact product with the gradient
  always_comb begin
    d_ext          = (sfb_pkg::P_W + 1)'($signed({1'b0, deriv.d}));
    g_ext          = (sfb_pkg::P_W + 1)'(deriv.grad);
    p_full         = d_ext * g_ext;
    prod_next.op   = deriv.op;
    prod_next.fwd  = deriv.fwd;
    prod_next.p    = p_full[sfb_pkg::P_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
    end
  end

  // stage 6: round half up to the output format; |p| <= 2^45 keeps it in range
  always_comb begin
    rsum = (sfb_pkg::P_W + 1)'(prod.p) + BWD_HALF;
    case (prod.op)
      sfb_pkg::OP_FWD: value_next = prod.fwd;
      sfb_pkg::OP_BWD: value_next = rsum[sfb_pkg::P_W -: sfb_pkg::DATA_W];
      default:         value_next = prod.fwd;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= value_next;
    end
  end

  // forward answer stays within [0, 1.0]
  a_fwd_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (deriv.fwd >= 0) && (deriv.fwd <= sfb_pkg::DATA_W'(1 << sfb_pkg::FRAC_BITS)))
    else $error("forward value out of [0, 1.0]");

  // s*(1-s) never above one quarter
  a_deriv_peak: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (deriv.d <= sfb_pkg::D_W'(1 << 30)))
    else $error("derivative above 0.25");

  // a valid product reaches the output register on the next enabled edge
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (en && v5) |=> out_valid)
    else $error("product stage item lost");

  // a stalled product stage holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!en && v5) |=> (v5 && $stable(prod)))
    else $error("product stage changed during stall");

endmodule

`default_nettype wire

// File: hw/rtl/sigmoid_forward_backward_core.sv
// ----------------------------------------------------------------------------
// sigmoid_forward_backward_core: logistic activation with derivative path
// streaming elementwise sigmoid (forward) or s*(1-s)*grad (backward)
// ----------------------------------------------------------------------------
// usage:
//   the slave stream carries one element per transfer: tdata holds z and the
//   gradient, both signed q3.12, tuser holds the op bit (0 forward, 1 backward)
//   the master stream returns one signed q3.12 value per element, in order
// stages: an accepted input transfer passes through the magnitude, table read,
//   interpolation, s*(1-s), gradient product and round stages to m_tvalid
// throughput: one element per cycle while the output is not stalled; the table
//   and the three multipliers are each used once per element in their own stage
// stall: the whole pipeline advances together; while the output register
//   holds an unaccepted result, every stage freezes and s_tready drops, so
//   nothing is lost or repeated; bubbles travel as cleared valid bits
// reset: rst (synchronous, active high) clears all valid bits; the sigmoid
//   table is constant logic and needs no loading
// ----------------------------------------------------------------------------
`default_nettype none

module sigmoid_forward_backward_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] z, [31:16] grad
  input  wire logic        s_tuser,   // [0] op
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [15:0] value
);

  // pipeline advance: empty output slot or the receiver takes it now
  logic                                en;

  sfb_pkg::op_t                        in_op;
  logic signed [sfb_pkg::DATA_W-1:0]   in_z;
  logic signed [sfb_pkg::DATA_W-1:0]   in_grad;

  logic                                lut_valid;
  sfb_pkg::lut_t                       lut_data;
  logic                                sig_valid;
  sfb_pkg::sig_t                       sig_data;
  logic signed [sfb_pkg::DATA_W-1:0]   value;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // field unpacking
  assign in_op   = sfb_pkg::op_t'(s_tuser);
  assign in_z    = s_tdata[15:0];
  assign in_grad = s_tdata[31:16];

  // stages 1-2: |z| with saturation, table lookup of both neighbors
  sfb_lookup u_lookup (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_op     (in_op),
    .in_z      (in_z),
    .in_grad   (in_grad),
    .out_valid (lut_valid),
    .out_data  (lut_data)
  );

  // stage 3: interpolation and sign fold
  sfb_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (lut_valid),
    .in_data   (lut_data),
    .out_valid (sig_valid),
    .out_data  (sig_data)
  );

  // stages 4-6: derivative, gradient product, rounding; stage 6 is the
  // output register
  sfb_deriv u_deriv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sig_valid),
    .in_data   (sig_data),
    .out_valid (m_tvalid),
    .out_value (value)
  );

  assign m_tdata = value;

endmodule

`default_nettype wire

// File: tb/tb_sigmoid_forward_backward_core.sv
// ----------------------------------------------------------------------------
// tb_sigmoid_forward_backward_core: self-checking bench for the sigmoid core
// drives forward and backward elements through the input stream under several
// idle/stall mixes, predicts each answer with an integer sigmoid table and
// interpolation, and compares every output transfer in order
// ----------------------------------------------------------------------------

module tb_sigmoid_forward_backward_core;

  localparam int TBL_BITS  = sfb_pkg::TABLE_BITS;
  localparam int FRAC      = sfb_pkg::FRAC_BITS;
  localparam int TBL_SIZE  = (1 << TBL_BITS) + 1;
  localparam int POS_W     = 19 - TBL_BITS;
  localparam int RAW_CAP   = (8 << FRAC) - 1;
  localparam int MAG_CAP   = (RAW_CAP > 32767) ? 32767 : RAW_CAP;
  localparam int PIPE_LAT  = 6;
  localparam int STALL_CAP = 10000;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    sfb_pkg::op_t op;
    logic [15:0]  z;
    logic [15:0]  grad;
    logic [15:0]  value;
  } act_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // sigmoid samples in q0.16, built from an integer series for e^x
  longint unsigned sig_table [TBL_SIZE];

  act_result_t pending_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int fwd_checked    = 0;
  int bwd_checked    = 0;
  int elems_sent     = 0;
  int quiet_cycles   = 0;

  sigmoid_forward_backward_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [15:0] z, [31:16] grad
    .s_tuser  (s_tuser),   // [0] op
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [15:0] value
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sigmoid table entry k: e^x in q32 by truncated series, then
  // round(65536*E/(E+2^32)) with ties going up
  // ---------------------------------------------------------------------------
  function automatic longint unsigned sig_table_entry(int unsigned k);
    longint unsigned term;
    longint unsigned exp_q32;
    longint unsigned den;
    int unsigned     n;
    term    = 64'd1 << 32;
    exp_q32 = term;
    n       = 1;
    while (n < 200 && term != 0) begin
      term    = (term * k * 8) / ((64'd1 << TBL_BITS) * n);
      exp_q32 = exp_q32 + term;
      n++;
    end
    den = exp_q32 + (64'd1 << 32);
    return (exp_q32 * 131072 + den) / (2 * den);
  endfunction

  // ---------------------------------------------------------------------------
  // expected output of one element
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] predict_activation(sfb_pkg::op_t op, logic [15:0] z,
                                                     logic [15:0] grad);
    logic            neg;
    longint unsigned mag;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned fr;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned s;
    longint unsigned fwd;
    longint unsigned d;
    longint          prod;
    longint          res;
    neg = z[15];
    mag = neg ? (64'h10000 - longint'(z)) : longint'(z);
    // magnitude saturates just below 8.0, so the most negative z lands here too
    if (mag > MAG_CAP)
      mag = MAG_CAP;
    pos = mag << (16 - FRAC);
    idx = (pos >> POS_W) & ((64'd1 << TBL_BITS) - 1);
    fr  = pos & ((64'd1 << POS_W) - 1);
    lo  = sig_table[idx];
    hi  = sig_table[idx + 1];
    s   = lo;
    if (hi > lo)
      s = s + (((hi - lo) * fr + (64'd1 << (POS_W - 1))) >> POS_W);
    if (s > 65536)
      s = 65536;
    if (neg)
      s = 65536 - s;
    if (op == sfb_pkg::OP_FWD) begin
      // grad plays no part here
      fwd = (s + (64'd1 << (15 - FRAC))) >> (16 - FRAC);
      if (fwd > 32767)
        fwd = 32767;
      res = longint'(fwd);
    end else begin
      d    = s * (65536 - s);
      prod = longint'(d) * longint'($signed(grad));
      res  = (prod + (longint'(1) << 31)) >>> 32;
      if (res > 32767)
        res = 32767;
      if (res < -32768)
        res = -32768;
    end
    return res[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // sender: random idle gaps, then hold the element until its transfer
  // ---------------------------------------------------------------------------
  task automatic send_element(sfb_pkg::op_t op, logic [15:0] z, logic [15:0] grad);
    act_result_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {16'($urandom_range(65535)), 16'($urandom_range(65535))};
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {grad, z};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    item.op    = op;
    item.z     = z;
    item.grad  = grad;
    item.value = predict_activation(op, z, grad);
    pending_results.push_back(item);
    elems_sent++;
  endtask

  // hold off the input until every outstanding result has come back
  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // output checker: each transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    act_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("ERROR: unexpected output transfer value=%0d", $signed(m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (want.op == sfb_pkg::OP_FWD)
          fwd_checked++;
        else
          bwd_checked++;
        if (m_tdata !== want.value) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("ERROR: op=%s z=%0d grad=%0d value expected %0d got %0d",
                     want.op.name(), $signed(want.z), $signed(want.grad),
                     $signed(want.value), $signed(m_tdata));
        end
      end
    end
  end

  // watchdog: too long without a transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_CAP) begin
        $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, both ops, table boundaries and the saturating magnitude
  task automatic test_directed();
    send_element(sfb_pkg::OP_FWD, 16'h0000, 16'h0000);
    send_element(sfb_pkg::OP_FWD, 16'h0001, 16'h0000);
    send_element(sfb_pkg::OP_FWD, 16'hFFFF, 16'h0000);
    send_element(sfb_pkg::OP_FWD, 16'h7FFF, 16'h0000);
    send_element(sfb_pkg::OP_FWD, 16'h8000, 16'h0000);
    send_element(sfb_pkg::OP_FWD, 16'h8001, 16'h0000);
    // exactly on a table entry, and the largest fraction below the next one
    send_element(sfb_pkg::OP_FWD, 16'h0080, 16'h0000);
    send_element(sfb_pkg::OP_FWD, 16'h007F, 16'h0000);
    send_element(sfb_pkg::OP_FWD, 16'h7F80, 16'h0000);
    // gradient must be ignored on the forward path
    send_element(sfb_pkg::OP_FWD, 16'hF000, 16'h7FFF);
    send_element(sfb_pkg::OP_FWD, 16'h1000, 16'h8000);
    send_element(sfb_pkg::OP_BWD, 16'h0000, 16'h7FFF);
    send_element(sfb_pkg::OP_BWD, 16'h0000, 16'h8000);
    send_element(sfb_pkg::OP_BWD, 16'h0000, 16'h0001);
    send_element(sfb_pkg::OP_BWD, 16'h0000, 16'hFFFF);
    send_element(sfb_pkg::OP_BWD, 16'h0000, 16'h0000);
    send_element(sfb_pkg::OP_BWD, 16'h7FFF, 16'h7FFF);
    send_element(sfb_pkg::OP_BWD, 16'h8000, 16'h8000);
    send_element(sfb_pkg::OP_BWD, 16'h1000, 16'h1000);
    send_element(sfb_pkg::OP_BWD, 16'hF000, 16'h1000);
    send_element(sfb_pkg::OP_BWD, 16'h5555, 16'hAAAA);
    send_element(sfb_pkg::OP_BWD, 16'hAAAA, 16'h5555);
    send_element(sfb_pkg::OP_BWD, 16'h0001, 16'h8000);
  endtask

  // random ops; half the z values stay within the interesting +-2 region
  task automatic run_random(int count);
    logic [15:0] z;
    logic [15:0] grad;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1) == 1) begin
        z = 16'($urandom_range(8191));
        if ($urandom_range(1) == 1)
          z = -z;
      end else begin
        z = 16'($urandom_range(65535));
      end
      grad = 16'($urandom_range(65535));
      send_element(sfb_pkg::op_t'($urandom_range(1)), z, grad);
    end
  endtask

  task automatic test_no_idling();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(330);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 57;
    recv_stall_pct = 0;
    run_random(330);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 57;
    run_random(330);
  endtask

  // mixed idling with a full drain in the middle
  task automatic test_both_idle_with_pause();
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    run_random(160);
    wait_until_drained();
    run_random(170);
  endtask

  initial begin
    for (int k = 0; k < TBL_SIZE; k++)
      sig_table[k] = sig_table_entry(k);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle_with_pause();

    wait_until_drained();
    repeat (PIPE_LAT + 10) @(posedge clk);

    $display("covered %0d elements: %0d forward and %0d backward results checked",
             elems_sent, fwd_checked, bwd_checked);
    $display("idle mixes: none, sender 57%%, receiver 57%%, both 15%% plus a drain pause");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("mismatches: %0d, results outstanding: %0d", mismatches,
               pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/sfb_pkg.sv
hw/rtl/sfb_lookup.sv
hw/rtl/sfb_interp.sv
hw/rtl/sfb_deriv.sv
hw/rtl/sigmoid_forward_backward_core.sv
tb/tb_sigmoid_forward_backward_core.sv
